// ----- rtl/rcsfd_pkg.sv -----
// Package for the serial RC frame decoder.
// Holds item kind, status, event and register index codes and frame constants.
// No dependencies.
package rcsfd_pkg;

  localparam int FRAME_BYTES  = 25;
  localparam int NUM_CHANNELS = 18;
  localparam int PAYLOAD_LEN  = FRAME_BYTES - 2;
  localparam int NUM_PACKED   = 16;
  localparam int CH_W         = 11;
  localparam int POS_W        = 5;
  localparam int IDX_W        = 5;

  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [1:0] STATUS_VALID   = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
  localparam logic [1:0] STATUS_NO_CH   = 2'd2;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_GOOD      = 3'd1;
  localparam logic [2:0] EV_FAILSAFE  = 3'd2;
  localparam logic [2:0] EV_LOST      = 3'd3;
  localparam logic [2:0] EV_DISCARD   = 3'd4;
  localparam logic [2:0] EV_TICK_TOUT = 3'd5;

  localparam logic [2:0] REG_START_BYTE     = 3'd0;
  localparam logic [2:0] REG_END_BYTE       = 3'd1;
  localparam logic [2:0] REG_RESYNC_TICKS   = 3'd2;
  localparam logic [2:0] REG_FAILSAFE_TICKS = 3'd3;
  localparam logic [2:0] REG_DISCRETE_HIGH  = 3'd4;
  localparam logic [2:0] REG_DISCRETE_LOW   = 3'd5;

  localparam int FLAG_DC1      = 0;
  localparam int FLAG_DC2      = 1;
  localparam int FLAG_LOST     = 2;
  localparam int FLAG_FAILSAFE = 3;

  // Bit 11 is the timeout flag, bits 10..0 the channel value.
  typedef logic [CH_W:0] chan_entry_t;

  localparam chan_entry_t CHAN_TIMEOUT = {1'b1, {CH_W{1'b0}}};

endpackage

// ----- rtl/rc_serial_frame_decoder_top.sv -----
// Serial RC frame decoder: frame sync, payload capture, channel unpack and failsafe.
// An accepted item's result is registered for the next cycle; one item per cycle
// is sustained while m_tready is high; the single result register frees itself once taken.
// Synchronous active-high reset sets the channels to timeout and disarms sync.
// Depends on rcsfd_pkg.
module rc_serial_frame_decoder_top
  import rcsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // byte_value [7:0], channel_index [12:8], zero [15:13]
  input  logic [1:0]  s_tuser,   // func [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // channel_value [10:0], frame_event [13:11], zero [15:14]
  output logic [1:0]  m_tuser,   // channel_status [1:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

  logic [7:0]        start_byte;
  logic [7:0]        end_byte;
  logic [3:0]        resync_ticks;
  logic [7:0]        failsafe_ticks;
  logic [CH_W-1:0]   discrete_high;
  logic [CH_W-1:0]   discrete_low;

  chan_entry_t       channel_store [NUM_CHANNELS];
  chan_entry_t       channel_store_next [NUM_CHANNELS];
  logic [7:0]        payload_buffer [PAYLOAD_LEN];
  logic [3:0]        idle_tick_count, idle_tick_count_next;
  logic [7:0]        failsafe_tick_count, failsafe_tick_count_next;
  logic              sync_armed, sync_armed_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;

  logic              pb_we;
  logic [POS_W-1:0]  pb_addr;

  logic [CH_W-1:0]   out_value, out_value_next;
  logic [1:0]        out_status, out_status_next;
  logic [2:0]        out_event, out_event_next;

  logic              accept;
  logic [1:0]        func;
  logic [7:0]        byte_value;
  logic [IDX_W-1:0]  channel_index;
  logic [PAYLOAD_LEN*8-1:0] payload_flat;
  logic [7:0]        flags;
  logic [4:0]        idle_inc;
  logic [8:0]        fs_inc;

  assign s_tready      = !m_tvalid || m_tready;
  assign accept        = s_tvalid && s_tready;
  assign func          = s_tuser;
  assign byte_value    = s_tdata[7:0];
  assign channel_index = s_tdata[12:8];
  assign flags         = payload_buffer[PAYLOAD_LEN-1];
  assign idle_inc      = {1'b0, idle_tick_count} + 5'd1;
  assign fs_inc        = {1'b0, failsafe_tick_count} + 9'd1;

  assign m_tdata = {2'b00, out_event, out_value};
  assign m_tuser = out_status;

  always_comb begin
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      payload_flat[i*8 +: 8] = payload_buffer[i];
    end
  end

  always_comb begin
    channel_store_next       = channel_store;
    idle_tick_count_next     = idle_tick_count;
    failsafe_tick_count_next = failsafe_tick_count;
    sync_armed_next          = sync_armed;
    byte_position_next       = byte_position;
    pb_we                    = 1'b0;
    pb_addr                  = byte_position - POS_W'(1);
    out_value_next           = '0;
    out_status_next          = STATUS_VALID;
    out_event_next           = EV_NONE;
    case (func)
      FUNC_BYTE: begin
        idle_tick_count_next = '0;
        if (sync_armed) begin
          if (byte_position == '0) begin
            if (byte_value != start_byte) begin
              sync_armed_next = 1'b0;
              out_event_next  = EV_DISCARD;
            end else begin
              byte_position_next = POS_W'(1);
            end
          end else if (byte_position < POS_W'(FRAME_BYTES - 1)) begin
            pb_we              = 1'b1;
            byte_position_next = byte_position + POS_W'(1);
          end else begin
            sync_armed_next = 1'b0;
            if (byte_value == end_byte) begin
              if (flags[FLAG_LOST]) begin
                out_event_next = EV_LOST;
              end else if (flags[FLAG_FAILSAFE]) begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                  channel_store_next[i] = CHAN_TIMEOUT;
                end
                out_event_next = EV_FAILSAFE;
              end else begin
                for (int i = 0; i < NUM_PACKED; i++) begin
                  channel_store_next[i] = {1'b0, payload_flat[i*CH_W +: CH_W]};
                end
                channel_store_next[NUM_PACKED] =
                  {1'b0, flags[FLAG_DC1] ? discrete_high : discrete_low};
                channel_store_next[NUM_PACKED+1] =
                  {1'b0, flags[FLAG_DC2] ? discrete_high : discrete_low};
                failsafe_tick_count_next = '0;
                out_event_next           = EV_GOOD;
              end
            end else begin
              out_event_next = EV_DISCARD;
            end
          end
        end
      end
      FUNC_TICK: begin
        if (idle_inc > {1'b0, resync_ticks}) begin
          sync_armed_next      = 1'b1;
          byte_position_next   = '0;
          idle_tick_count_next = '0;
        end else begin
          idle_tick_count_next = idle_inc[3:0];
        end
        if (fs_inc > {1'b0, failsafe_ticks}) begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            channel_store_next[i] = CHAN_TIMEOUT;
          end
          failsafe_tick_count_next = '0;
          out_event_next           = EV_TICK_TOUT;
        end else begin
          failsafe_tick_count_next = fs_inc[7:0];
        end
      end
      FUNC_READ: begin
        if (channel_index >= IDX_W'(NUM_CHANNELS)) begin
          out_status_next = STATUS_NO_CH;
        end else if (channel_store[channel_index][CH_W]) begin
          out_status_next = STATUS_TIMEOUT;
        end else begin
          out_value_next = channel_store[channel_index][CH_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte          <= 8'd15;
      end_byte            <= 8'd0;
      resync_ticks        <= 4'd2;
      failsafe_ticks      <= 8'd64;
      discrete_high       <= 11'd1696;
      discrete_low        <= 11'd352;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        channel_store[i] <= CHAN_TIMEOUT;
      end
      idle_tick_count     <= '0;
      failsafe_tick_count <= '0;
      sync_armed          <= 1'b0;
      byte_position       <= '0;
      m_tvalid            <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_BYTE:     start_byte     <= cfg_wdata[7:0];
          REG_END_BYTE:       end_byte       <= cfg_wdata[7:0];
          REG_RESYNC_TICKS:   resync_ticks   <= cfg_wdata[3:0];
          REG_FAILSAFE_TICKS: failsafe_ticks <= cfg_wdata[7:0];
          REG_DISCRETE_HIGH:  discrete_high  <= cfg_wdata;
          REG_DISCRETE_LOW:   discrete_low   <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (accept) begin
        channel_store       <= channel_store_next;
        idle_tick_count     <= idle_tick_count_next;
        failsafe_tick_count <= failsafe_tick_count_next;
        sync_armed          <= sync_armed_next;
        byte_position       <= byte_position_next;
        m_tvalid            <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pb_we) begin
      payload_buffer[pb_addr] <= byte_value;
    end
    if (accept) begin
      out_value  <= out_value_next;
      out_status <= out_status_next;
      out_event  <= out_event_next;
    end
  end

endmodule
